/* hdl/kelr_pkg.sv */
// Types, key codes and layer tables shared by the key event layer remapper.
`default_nettype none
package kelr_pkg;

    localparam int LAYER_KEYS = 33;
    localparam int LAYER_IDX_W = $clog2(LAYER_KEYS);
    localparam int MAX_RES = 3;

    localparam logic [4:0] TYPE_SYN = 5'd0;
    localparam logic [4:0] TYPE_KEY = 5'd1;

    localparam logic [15:0] KEY_ESC      = 16'd1;
    localparam logic [15:0] KEY_BACKTICK = 16'd41;
    localparam logic [15:0] KEY_CAPS     = 16'd58;
    localparam logic [15:0] KEY_PRTSC    = 16'd99;
    localparam logic [15:0] KEY_MENU     = 16'd127;
    localparam logic [15:0] KEY_RETURN   = 16'd28;
    localparam logic [15:0] KEY_RCTRL    = 16'd97;
    localparam logic [15:0] KEY_RALT     = 16'd100;
    localparam logic [15:0] CODE_NONE    = 16'd0;

    localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
    localparam logic signed [31:0] VAL_PRESS   = 32'sd1;

    localparam logic [15:0] LAYER_SRC [LAYER_KEYS] = '{
        16'd35, 16'd36, 16'd37, 16'd38, 16'd24, 16'd25, 16'd26, 16'd27,
        16'd50, 16'd51, 16'd52,
        16'd2,  16'd3,  16'd4,  16'd5,  16'd6,  16'd7,  16'd8,  16'd9,
        16'd10, 16'd11, 16'd12, 16'd13,
        16'd47, 16'd44, 16'd45, 16'd46, 16'd30, 16'd31, 16'd32, 16'd16,
        16'd17, 16'd18
    };

    localparam logic [15:0] LAYER_DST [LAYER_KEYS] = '{
        16'd105, 16'd108, 16'd103, 16'd106, 16'd102, 16'd107, 16'd104, 16'd109,
        16'd113, 16'd114, 16'd115,
        16'd59,  16'd60,  16'd61,  16'd62,  16'd63,  16'd64,  16'd65,  16'd66,
        16'd67,  16'd68,  16'd87,  16'd88,
        16'd11,  16'd2,   16'd3,   16'd4,   16'd5,   16'd6,   16'd7,   16'd8,
        16'd9,   16'd10
    };

    typedef struct packed {
        logic [4:0]         ev_type;
        logic [15:0]        code;
        logic signed [31:0] value;
    } t_kevent;

    typedef struct packed {
        logic                  alt_held;
        logic                  enter_held;
        logic                  enter_used;
        logic [LAYER_KEYS-1:0] layer_set;
    } t_kstate;

endpackage
`default_nettype wire

/* hdl/key_event_layer_remapper.sv */
// Top level of the key event layer remapper: input register, translation, result buffer.
`default_nettype none
// Each accepted item is held in an input register, translated combinationally and
// loaded into a three-entry result buffer that drains one result per cycle while
// i_stall is low. An item that yields one result is taken every cycle while i_stall
// is low; an item that yields three results holds the output for all three, and a
// Right Alt event or an Enter press yields none. The input register takes the next
// item while the buffer still holds results, so the throughput is set by the number
// of results per item at the output port. An item passes the input register and then
// the result buffer. o_last marks the final result of each item that yields any.
module key_event_layer_remapper
    import kelr_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire [4:0]          i_event_type,
    input  wire [15:0]         i_event_code,
    input  wire signed [31:0]  i_event_value,
    output logic               o_valid,
    input  wire                i_stall,
    output logic [4:0]         o_out_type,
    output logic [15:0]        o_out_code,
    output logic signed [31:0] o_out_value,
    output logic               o_last
);

    logic          r_in_vld;
    t_kevent       r_in;
    t_kstate       r_state;
    t_kevent [2:0] r_buf;
    logic [1:0]    r_cnt;
    logic [1:0]    r_idx;

    t_kstate       n_state;
    t_kevent [2:0] n_res;
    logic [1:0]    n_num;
    t_kevent       sel;
    logic          last_taken;
    logic          move;
    logic          in_acc;

    kelr_xlate u_xlate (
        .i_ev    (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_res),
        .o_num   (n_num)
    );

    always_comb begin
        case (r_idx)
            2'd0:    sel = r_buf[0];
            2'd1:    sel = r_buf[1];
            2'd2:    sel = r_buf[2];
            default: sel = r_buf[0];
        endcase
    end

    assign o_valid     = (r_cnt != 2'd0);
    assign o_last      = (r_idx == (r_cnt - 2'd1));
    assign o_out_type  = sel.ev_type;
    assign o_out_code  = sel.code;
    assign o_out_value = sel.value;

    assign last_taken = o_valid && !i_stall && o_last;
    assign move       = r_in_vld && (!o_valid || last_taken);
    assign o_stall    = r_in_vld && !move;
    assign in_acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= '{ev_type: i_event_type, code: i_event_code, value: i_event_value};
        end
        if (move) begin
            r_buf <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_state  <= '0;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_state <= n_state;
                r_cnt   <= n_num;
                r_idx   <= 2'd0;
            end else if (last_taken) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else if (o_valid && !i_stall) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/kelr_xlate.sv */
// Translation of one input event into up to three output events and next state.
`default_nettype none
module kelr_xlate
    import kelr_pkg::*;
(
    input  wire t_kevent    i_ev,
    input  wire t_kstate    i_state,
    output t_kstate         o_state,
    output t_kevent [2:0]   o_res,
    output logic [1:0]      o_num
);

    logic [15:0]            code;
    logic                   press;
    logic                   hit;
    logic [LAYER_IDX_W-1:0] idx;
    logic [15:0]            dst;
    logic [LAYER_KEYS-1:0]  bitmask;
    logic [15:0]            out_code;

    // fixed swaps
    always_comb begin
        case (i_ev.code)
            KEY_CAPS:  code = KEY_ESC;
            KEY_ESC:   code = KEY_BACKTICK;
            KEY_PRTSC: code = KEY_MENU;
            default:   code = i_ev.code;
        endcase
    end

    // layer source codes are distinct, so at most one entry matches
    always_comb begin
        hit = 1'b0;
        idx = '0;
        dst = '0;
        for (int i = 0; i < LAYER_KEYS; i++) begin
            if (LAYER_SRC[i] == code) begin
                hit = 1'b1;
                idx = LAYER_IDX_W'(i);
                dst = LAYER_DST[i];
            end
        end
    end

    assign press   = (i_ev.value != VAL_RELEASE);
    assign bitmask = hit ? (LAYER_KEYS'(1) << idx) : '0;

    always_comb begin
        o_state  = i_state;
        o_res[0] = i_ev;
        o_res[1] = '{ev_type: TYPE_SYN, code: CODE_NONE, value: VAL_RELEASE};
        o_res[2] = '{ev_type: TYPE_SYN, code: CODE_NONE, value: VAL_RELEASE};
        o_num    = 2'd1;
        out_code = code;
        if (i_ev.ev_type != TYPE_KEY) begin
            o_num = 2'd1;
        end else if (!press && ((i_state.layer_set & bitmask) != '0)) begin
            // release of a key recorded under the layer
            o_state.layer_set = i_state.layer_set & ~bitmask;
            o_res[0] = '{ev_type: TYPE_KEY, code: dst, value: i_ev.value};
        end else if (code == KEY_RETURN) begin
            if (!press) begin
                if (!i_state.enter_used) begin
                    o_res[0] = '{ev_type: TYPE_KEY, code: KEY_RETURN, value: VAL_PRESS};
                    o_res[2] = '{ev_type: TYPE_KEY, code: KEY_RETURN, value: VAL_RELEASE};
                    o_num    = 2'd3;
                end else begin
                    o_res[0] = '{ev_type: TYPE_KEY, code: KEY_RCTRL, value: VAL_RELEASE};
                end
                o_state.enter_used = 1'b0;
                o_state.enter_held = 1'b0;
            end else begin
                o_state.enter_held = 1'b1;
                o_num = 2'd0;
            end
        end else if (code == KEY_RALT) begin
            o_state.alt_held = press;
            o_num = 2'd0;
        end else begin
            if (i_state.alt_held && hit && press) begin
                o_state.layer_set = i_state.layer_set | bitmask;
                out_code = dst;
            end
            if (press && i_state.enter_held && !i_state.enter_used) begin
                // Enter acts as Right Ctrl from here on
                o_state.enter_used = 1'b1;
                o_res[0] = '{ev_type: TYPE_KEY, code: KEY_RCTRL, value: VAL_PRESS};
                o_res[1] = '{ev_type: TYPE_KEY, code: out_code, value: i_ev.value};
                o_num    = 2'd3;
            end else begin
                o_res[0] = '{ev_type: TYPE_KEY, code: out_code, value: i_ev.value};
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/kelr_checker.sv */
// Port-level checks for the key event layer remapper, bound to the top level.
`default_nettype none
module kelr_checker
    import kelr_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_stall,
    input wire               o_valid,
    input wire               i_stall,
    input wire [4:0]         o_out_type,
    input wire [15:0]        o_out_code,
    input wire signed [31:0] o_out_value,
    input wire               o_last
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_code) && $stable(o_out_value)
            && $stable(o_last))
        else $error("stalled result changed");

    // an empty output side never stalls the input
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // the tap sequence: Enter down is followed by a sync report
    a_tap_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last && o_out_type == TYPE_KEY
            && o_out_code == KEY_RETURN
        |=> o_valid && o_out_type == TYPE_SYN && !o_last)
        else $error("Enter down not followed by sync");

    // a sync report inside a group only precedes the Enter release
    a_tap_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last && o_out_type == TYPE_SYN
        |=> o_valid && o_last && o_out_type == TYPE_KEY && o_out_code == KEY_RETURN
            && o_out_value == VAL_RELEASE)
        else $error("sync not followed by Enter up");

endmodule

bind key_event_layer_remapper kelr_checker u_kelr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_type  (o_out_type),
    .o_out_code  (o_out_code),
    .o_out_value (o_out_value),
    .o_last      (o_last)
);
`default_nettype wire

/* tb/key_event_layer_remapper_test.sv */
// Self-checking testbench for the key event layer remapper: random and directed key items.
`timescale 1ns / 100ps
module key_event_layer_remapper_test;
    import kelr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT = 60;
    localparam int HOLD_LEN = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 80;

    typedef struct packed {
        logic [4:0]         ev_type;
        logic [15:0]        code;
        logic signed [31:0] value;
        logic               last;
    } t_remapped;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [4:0]         i_event_type = '0;
    logic [15:0]        i_event_code = '0;
    logic signed [31:0] i_event_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [4:0]         o_out_type;
    logic [15:0]        o_out_code;
    logic signed [31:0] o_out_value;
    logic               o_last;

    key_event_layer_remapper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_event_type  (i_event_type),
        .i_event_code  (i_event_code),
        .i_event_value (i_event_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_type    (o_out_type),
        .o_out_code    (o_out_code),
        .o_out_value   (o_out_value),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_kevent   pending_events[$];
    t_remapped expected_outs[$];
    int        mismatches = 0;
    int        send_idle_pct = 31;
    int        recv_idle_pct = 57;

    // predictor state
    logic                  alt_down = 1'b0;
    logic                  enter_down = 1'b0;
    logic                  enter_as_ctrl = 1'b0;
    logic [LAYER_KEYS-1:0] layer_keys_down = '0;

    function automatic int layer_slot(input logic [15:0] c);
        for (int i = 0; i < LAYER_KEYS; i++)
            if (LAYER_SRC[i] == c)
                return i;
        return -1;
    endfunction

    function automatic void remap_event(input logic [4:0] t, input logic [15:0] c_in,
                                        input logic signed [31:0] v);
        t_remapped  outs[$];
        logic [15:0] c;
        logic        press;
        int          slot;
        c = c_in;
        press = (v != 0);
        if (t != TYPE_KEY) begin
            outs.push_back('{t, c_in, v, 1'b0});
        end else begin
            case (c_in)
                KEY_CAPS:  c = KEY_ESC;
                KEY_ESC:   c = KEY_BACKTICK;
                KEY_PRTSC: c = KEY_MENU;
                default: ;
            endcase
            slot = layer_slot(c);
            if (!press && slot >= 0 && layer_keys_down[slot]) begin
                // release of a key pressed under the layer stays mapped
                layer_keys_down[slot] = 1'b0;
                outs.push_back('{TYPE_KEY, LAYER_DST[slot], v, 1'b0});
            end else if (c == KEY_RETURN) begin
                if (!press) begin
                    if (!enter_as_ctrl) begin
                        outs.push_back('{TYPE_KEY, KEY_RETURN, VAL_PRESS, 1'b0});
                        outs.push_back('{TYPE_SYN, CODE_NONE, VAL_RELEASE, 1'b0});
                        outs.push_back('{TYPE_KEY, KEY_RETURN, VAL_RELEASE, 1'b0});
                    end else begin
                        outs.push_back('{TYPE_KEY, KEY_RCTRL, VAL_RELEASE, 1'b0});
                    end
                    enter_as_ctrl = 1'b0;
                    enter_down = 1'b0;
                end else begin
                    enter_down = 1'b1;
                end
            end else if (c == KEY_RALT) begin
                alt_down = press;
            end else begin
                if (alt_down && slot >= 0 && press) begin
                    layer_keys_down[slot] = 1'b1;
                    c = LAYER_DST[slot];
                end
                if (press && enter_down && !enter_as_ctrl) begin
                    enter_as_ctrl = 1'b1;
                    outs.push_back('{TYPE_KEY, KEY_RCTRL, VAL_PRESS, 1'b0});
                    outs.push_back('{TYPE_KEY, c, v, 1'b0});
                    outs.push_back('{TYPE_SYN, CODE_NONE, VAL_RELEASE, 1'b0});
                end else begin
                    outs.push_back('{TYPE_KEY, c, v, 1'b0});
                end
            end
        end
        if (outs.size() != 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i])
            expected_outs.push_back(outs[i]);
    endfunction

    task automatic chk_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    // driver: hold the item while stalled, otherwise advance or idle
    t_kevent next_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_events.pop_front();
                i_valid <= 1'b1;
                i_event_type <= next_item.ev_type;
                i_event_code <= next_item.code;
                i_event_value <= next_item.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on input acceptance, check on output acceptance, drive stall
    t_remapped want;
    int        results_seen = 0;
    int        hold_left = 0;
    logic      hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                remap_event(i_event_type, i_event_code, i_event_value);
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_outs.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item expected none actual %0d/%0d/%0d/%0d",
                             $time, o_out_type, o_out_code, o_out_value, o_last);
                end else begin
                    want = expected_outs.pop_front();
                    chk_field("type", 32'(want.ev_type), 32'(o_out_type));
                    chk_field("code", 32'(want.code), 32'(o_out_code));
                    chk_field("value", want.value, o_out_value);
                    chk_field("last", 32'(want.last), 32'(o_last));
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT - 1) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus generator state, tracks what it has pressed
    logic                  gen_alt = 1'b0;
    logic                  gen_enter = 1'b0;
    logic [LAYER_KEYS-1:0] gen_down = '0;

    task automatic add_event(input logic [4:0] t, input logic [15:0] c,
                             input logic signed [31:0] v);
        t_kevent ev;
        ev.ev_type = t;
        ev.code = c;
        ev.value = v;
        pending_events.push_back(ev);
    endtask

    function automatic logic signed [31:0] press_value();
        int pick;
        pick = $urandom_range(9);
        if (pick < 8)
            return VAL_PRESS;
        else if (pick == 8)
            return 32'sd2;
        return 32'($urandom);
    endfunction

    task automatic queue_random(input int count);
        int                 pick;
        int                 slot;
        logic [15:0]        c;
        logic signed [31:0] v;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                add_event(5'($urandom_range(31)), 16'($urandom), 32'($urandom));
            end else if (pick < 22) begin
                gen_alt = !gen_alt;
                add_event(TYPE_KEY, KEY_RALT, gen_alt ? press_value() : VAL_RELEASE);
            end else if (pick < 34) begin
                gen_enter = !gen_enter;
                add_event(TYPE_KEY, KEY_RETURN, gen_enter ? press_value() : VAL_RELEASE);
            end else if (pick < 84) begin
                slot = $urandom_range(LAYER_KEYS - 1);
                if (gen_down[slot]) begin
                    gen_down[slot] = 1'b0;
                    v = VAL_RELEASE;
                end else begin
                    gen_down[slot] = 1'b1;
                    v = press_value();
                end
                add_event(TYPE_KEY, LAYER_SRC[slot], v);
            end else begin
                case ($urandom_range(3))
                    0: c = KEY_CAPS;
                    1: c = KEY_ESC;
                    2: c = KEY_PRTSC;
                    default: c = 16'($urandom);
                endcase
                add_event(TYPE_KEY, c, ($urandom_range(1) != 0) ? press_value() : VAL_RELEASE);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || i_valid || expected_outs.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        // non-key types pass through untouched
        add_event(TYPE_SYN, CODE_NONE, VAL_RELEASE);
        add_event(5'd31, 16'hFFFF, 32'sh7FFFFFFF);
        add_event(5'd2, KEY_RETURN, 32'sh80000000);
        // fixed swaps
        add_event(TYPE_KEY, KEY_CAPS, VAL_PRESS);
        add_event(TYPE_KEY, KEY_CAPS, VAL_RELEASE);
        add_event(TYPE_KEY, KEY_ESC, 32'sd2);
        add_event(TYPE_KEY, KEY_ESC, VAL_RELEASE);
        add_event(TYPE_KEY, KEY_PRTSC, VAL_PRESS);
        // Enter released without a press, then a tap, then Enter as Right Ctrl
        add_event(TYPE_KEY, KEY_RETURN, VAL_RELEASE);
        add_event(TYPE_KEY, KEY_RETURN, VAL_PRESS);
        add_event(TYPE_KEY, KEY_RETURN, VAL_RELEASE);
        add_event(TYPE_KEY, KEY_RETURN, VAL_PRESS);
        add_event(TYPE_KEY, 16'd30, VAL_PRESS);
        add_event(TYPE_KEY, 16'd31, VAL_PRESS);
        add_event(TYPE_KEY, 16'd30, VAL_RELEASE);
        add_event(TYPE_KEY, KEY_RETURN, VAL_RELEASE);
        // layer: unrecorded release, negative press, releases after Alt goes up
        add_event(TYPE_KEY, KEY_RALT, VAL_PRESS);
        add_event(TYPE_KEY, LAYER_SRC[0], VAL_PRESS);
        add_event(TYPE_KEY, LAYER_SRC[LAYER_KEYS-1], VAL_RELEASE);
        add_event(TYPE_KEY, LAYER_SRC[LAYER_KEYS-1], 32'shFFFFFFFF);
        add_event(TYPE_KEY, KEY_RALT, VAL_RELEASE);
        add_event(TYPE_KEY, LAYER_SRC[0], VAL_RELEASE);
        add_event(TYPE_KEY, LAYER_SRC[LAYER_KEYS-1], VAL_RELEASE);
        add_event(TYPE_KEY, 16'hFFFF, 32'sh7FFFFFFF);
        add_event(TYPE_KEY, CODE_NONE, 32'sh80000000);
        queue_random(ITEMS_PER_PHASE);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        wait_drained();
        send_idle_pct = 57;
        recv_idle_pct = 31;
        queue_random(ITEMS_PER_PHASE);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(ITEMS_PER_PHASE);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
